// ===== sv/vmt_pkg.sv =====
// Package for the vertex matrix transform: widths, register map, shared types.
`timescale 1ns / 1ps
`default_nettype none

package vmt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int CFG_W     = 2 * DATA_W;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int NUM_COMP  = 4;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int LATENCY   = 4;

   // register map, one register holds two columns of one row
   localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = REG_IDX_W'(4);
   localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = REG_IDX_W'(5);
   localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = REG_IDX_W'(6);
   localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = REG_IDX_W'(7);

   // 1.0 in the low and in the high column of a register
   localparam logic [CFG_W-1:0] ONE_LOW  = CFG_W'(1) << FRAC_BITS;
   localparam logic [CFG_W-1:0] ONE_HIGH = CFG_W'(1) << (FRAC_BITS + DATA_W);

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [NUM_COMP-1:0][DATA_W-1:0] quad_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } row_out_type;

endpackage

`default_nettype wire

// ===== sv/vmt_row.sv =====
// One matrix row dotted with the vector: multiply, two-level add tree, shift and clamp.
`timescale 1ns / 1ps
`default_nettype none

module vmt_row (
   input  wire logic                 clock,
   input  wire vmt_pkg::quad_type    coef,
   input  wire vmt_pkg::quad_type    vec,
   output vmt_pkg::row_out_type      result
);
   import vmt_pkg::*;

   logic signed [PROD_W-1:0] prod_ff [NUM_COMP];
   logic signed [PROD_W-1:0] prod_in [NUM_COMP];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [SUM_W-1:0]  total_ff;
   logic signed [SUM_W-1:0]  total_in;
   logic signed [SUM_W-1:0]  shifted;
   logic                     ovf_pos;
   logic                     ovf_neg;
   row_out_type              result_ff;
   row_out_type              result_in;

   // stage 1: four products
   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         prod_in[c] = PROD_W'($signed(coef[c]) * $signed(vec[c]));
      end
   end

   // stage 2 and 3: exact sum, no rounding on the way
   always_comb begin
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
      total_in   = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
   end

   // stage 4: floor shift, clamp to the data range
   always_comb begin
      shifted = total_ff >>> FRAC_BITS;
      ovf_pos = !shifted[SUM_W-1] && (|shifted[SUM_W-2:DATA_W-1]);
      ovf_neg = shifted[SUM_W-1] && !(&shifted[SUM_W-2:DATA_W-1]);
      result_in.sat = ovf_pos || ovf_neg;
      if (ovf_pos) begin
         result_in.value = DATA_MAX;
      end else if (ovf_neg) begin
         result_in.value = DATA_MIN;
      end else begin
         result_in.value = shifted[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_COMP; c++) begin
         prod_ff[c] <= prod_in[c];
      end
      pair_ff[0] <= pair_in[0];
      pair_ff[1] <= pair_in[1];
      total_ff   <= total_in;
      result_ff  <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== sv/vertex_matrix_transform.sv =====
// Top level: 4x4 fixed-point matrix times 4-component vector, fully pipelined.
//
//   channel  ports                                  direction  handshake
//   req      start, req_vec_x/y/z/w                  in         start & !busy
//   rsp      rsp_strobe, rsp_out_x/y/z/w, rsp_sat..  out        strobe, one cycle
//   csr      csr_wr_en, csr_index, csr_wdata         in         wr_en, no wait
//
// One word enters per clock; each word's result passes the multiply, pair add,
// final add and shift/clamp register stages before it leaves.
// busy stays low: nothing in the pipeline ever waits, so a new word can follow
// every cycle and the receiver cannot hold results off.
// Synchronous reset clears the valid bits and loads the identity matrix;
// data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module vertex_matrix_transform (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [vmt_pkg::DATA_W-1:0]      req_vec_x,
   input  wire logic [vmt_pkg::DATA_W-1:0]      req_vec_y,
   input  wire logic [vmt_pkg::DATA_W-1:0]      req_vec_z,
   input  wire logic [vmt_pkg::DATA_W-1:0]      req_vec_w,
   // response
   output logic                                 rsp_strobe,
   output logic [vmt_pkg::DATA_W-1:0]           rsp_out_x,
   output logic [vmt_pkg::DATA_W-1:0]           rsp_out_y,
   output logic [vmt_pkg::DATA_W-1:0]           rsp_out_z,
   output logic [vmt_pkg::DATA_W-1:0]           rsp_out_w,
   output logic                                 rsp_saturated,
   // configuration
   input  wire logic                            csr_wr_en,
   input  wire logic [vmt_pkg::REG_IDX_W-1:0]   csr_index,
   input  wire logic [vmt_pkg::CFG_W-1:0]       csr_wdata
);
   import vmt_pkg::*;

   logic [CFG_W-1:0]   matrix_ff [NUM_REGS];
   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;
   logic               accept;
   quad_type           vec;
   quad_type           row_coef [NUM_COMP];
   row_out_type        row_res  [NUM_COMP];

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign vec = {req_vec_w, req_vec_z, req_vec_y, req_vec_x};

   // matrix registers; the user must write only while no word is in flight, the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff[REG_ROW0_COLS01] <= ONE_LOW;
         matrix_ff[REG_ROW0_COLS23] <= '0;
         matrix_ff[REG_ROW1_COLS01] <= ONE_HIGH;
         matrix_ff[REG_ROW1_COLS23] <= '0;
         matrix_ff[REG_ROW2_COLS01] <= '0;
         matrix_ff[REG_ROW2_COLS23] <= ONE_LOW;
         matrix_ff[REG_ROW3_COLS01] <= '0;
         matrix_ff[REG_ROW3_COLS23] <= ONE_HIGH;
      end else if (csr_wr_en) begin
         matrix_ff[csr_index] <= csr_wdata;
      end
   end

   // valid bits ride alongside the row pipelines
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // one row unit per output component
   for (genvar r = 0; r < NUM_COMP; r++) begin : g_row
      assign row_coef[r] = {matrix_ff[2*r+1][CFG_W-1:DATA_W],
                            matrix_ff[2*r+1][DATA_W-1:0],
                            matrix_ff[2*r][CFG_W-1:DATA_W],
                            matrix_ff[2*r][DATA_W-1:0]};

      vmt_row u_row (
         .clock  (clock),
         .coef   (row_coef[r]),
         .vec    (vec),
         .result (row_res[r])
      );
   end

   assign rsp_strobe    = valid_ff[LATENCY-1];
   assign rsp_out_x     = row_res[0].value;
   assign rsp_out_y     = row_res[1].value;
   assign rsp_out_z     = row_res[2].value;
   assign rsp_out_w     = row_res[3].value;
   assign rsp_saturated = row_res[0].sat || row_res[1].sat
                       || row_res[2].sat || row_res[3].sat;

   // a taken word comes out as a strobe at the end of the valid pipeline
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("accepted word did not produce a strobe");

   // no strobe without a word taken at the head of the valid pipeline
   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 4))
      else $error("strobe without a matching request");

   // a clamp flag means some component sits on a rail
   a_sat_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |->
         (rsp_out_x == DATA_MAX || rsp_out_x == DATA_MIN ||
          rsp_out_y == DATA_MAX || rsp_out_y == DATA_MIN ||
          rsp_out_z == DATA_MAX || rsp_out_z == DATA_MIN ||
          rsp_out_w == DATA_MAX || rsp_out_w == DATA_MIN))
      else $error("saturated flag with no clamped component");

endmodule

`default_nettype wire
